// ===== hdl/fcbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbe_pkg
// Shared types and codes of the front-coding block encoder.
// ----------------------------------------------------------------------------
package fcbe_pkg;

    typedef enum logic [1:0]
    {
        CMD_CHAR  = 2'd0,
        CMD_END   = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_INDEX = 1'b1;

    typedef struct packed
    {
        logic [1:0] cmd;
        logic [7:0] ch;
    } item_t;

    typedef struct packed
    {
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] index_offset;
        logic        last;
    } result_t;

    // one step of the coder: at most one result, and whether the item is finished
    typedef struct packed
    {
        logic        emit;
        logic        done;
        logic        kind;
        logic [7:0]  data_byte;
        logic [31:0] index_offset;
    } step_t;

endpackage
`default_nettype wire

// ===== hdl/fcbe_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbe_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface fcbe_chan_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface
`default_nettype wire

// ===== hdl/fcbe_coder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbe_coder
// Coding state, previous-word store and the single-result step logic.
// ----------------------------------------------------------------------------
module fcbe_coder #(
    parameter int WORDS_PER_BLOCK = 16,
    parameter int WORD_BYTES      = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    cmd,
    input  wire logic [7:0]    ch,
    input  wire logic          fire,
    output fcbe_pkg::step_t    step
);
    import fcbe_pkg::*;

    localparam int PW = $clog2(WORD_BYTES);
    localparam int SW = $clog2(WORDS_PER_BLOCK);

    logic [7:0]    word_mem [WORD_BYTES];
    logic [7:0]    rd_data_reg;

    logic [PW-1:0] cpos_reg,   cpos_next;
    logic [PW-1:0] plen_reg,   plen_next;
    logic          match_reg,  match_next;
    logic [SW-1:0] slot_reg,   slot_next;
    logic          opened_reg, opened_next;
    logic [31:0]   offset_reg, offset_next;
    logic          pad_reg,    pad_next;

    logic wr_en;
    logic end_step;
    logic pad_step;
    logic flush_cont;
    logic slot_zero;
    logic slot_wrap;
    logic char_room;
    logic hit;

    assign slot_zero = (slot_reg == '0);
    assign slot_wrap = (slot_reg == SW'(WORDS_PER_BLOCK - 1));
    assign char_room = (cpos_reg < PW'(WORD_BYTES - 1));
    // rd_data_reg always holds the stored character at the current position
    assign hit       = (cpos_reg < plen_reg) && (rd_data_reg == ch);

    always_comb
    begin
        step        = '0;
        step.done   = 1'b1;
        step.kind   = KIND_DATA;
        cpos_next   = cpos_reg;
        plen_next   = plen_reg;
        match_next  = match_reg;
        slot_next   = slot_reg;
        opened_next = opened_reg;
        offset_next = offset_reg;
        pad_next    = pad_reg;
        wr_en       = 1'b0;
        end_step    = 1'b0;
        pad_step    = 1'b0;
        flush_cont  = 1'b0;

        case (cmd_e'(cmd))
            CMD_CHAR:
            begin
                if (ch != 8'd0)
                begin
                    if (!opened_reg)
                    begin
                        step.emit         = 1'b1;
                        step.kind         = KIND_INDEX;
                        step.index_offset = offset_reg;
                        opened_next       = 1'b1;
                        step.done = !(char_room && (slot_zero || !match_reg || !hit));
                    end
                    else if (!char_room)
                    begin
                        step.done = 1'b1;
                    end
                    else if (slot_zero || !match_reg)
                    begin
                        step.emit      = 1'b1;
                        step.data_byte = ch;
                        wr_en          = 1'b1;
                        cpos_next      = cpos_reg + 1'b1;
                    end
                    else if (hit)
                    begin
                        wr_en     = 1'b1;
                        cpos_next = cpos_reg + 1'b1;
                    end
                    else
                    begin
                        // shared prefix length first, the character on the next step
                        step.emit      = 1'b1;
                        step.data_byte = 8'(cpos_reg);
                        match_next     = 1'b0;
                        step.done      = 1'b0;
                    end
                end
            end
            CMD_END:
            begin
                end_step = 1'b1;
            end
            CMD_FLUSH:
            begin
                if (pad_reg)
                begin
                    pad_step = 1'b1;
                end
                else if (cpos_reg != '0)
                begin
                    end_step   = 1'b1;
                    flush_cont = 1'b1;
                end
                else if (!opened_reg && slot_zero)
                begin
                    // whole empty block: index entry, then one zero per slot
                    step.emit         = 1'b1;
                    step.kind         = KIND_INDEX;
                    step.index_offset = offset_reg;
                    opened_next       = 1'b1;
                    pad_next          = 1'b1;
                    step.done         = 1'b0;
                end
                else if (!slot_zero)
                begin
                    pad_step = 1'b1;
                end
                else
                begin
                    step.done = 1'b1;
                end
            end
            default:
            begin
                step.done = 1'b1;
            end
        endcase

        if (end_step)
        begin
            if (!opened_reg)
            begin
                step.emit         = 1'b1;
                step.kind         = KIND_INDEX;
                step.index_offset = offset_reg;
                opened_next       = 1'b1;
                step.done         = 1'b0;
            end
            else if (!slot_zero && (cpos_reg != '0) && match_reg)
            begin
                step.emit      = 1'b1;
                step.data_byte = 8'(cpos_reg);
                match_next     = 1'b0;
                step.done      = 1'b0;
            end
            else
            begin
                step.emit = 1'b1;
                step.done = !flush_cont;
                pad_step  = 1'b0;
            end
        end

        if (pad_step)
        begin
            step.emit = 1'b1;
            step.done = slot_wrap;
            pad_next  = 1'b1;
        end

        // zero terminator closes the word and moves to the next slot
        if ((end_step && step.emit && step.kind == KIND_DATA && step.data_byte == 8'd0
             && !(match_next != match_reg)) || pad_step)
        begin
            plen_next  = cpos_reg;
            cpos_next  = '0;
            match_next = 1'b1;
            if (slot_wrap)
            begin
                slot_next   = '0;
                opened_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end

        if (step.emit && step.kind == KIND_DATA)
        begin
            offset_next = offset_reg + 32'd1;
        end

        if (step.done)
        begin
            pad_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpos_reg   <= '0;
            plen_reg   <= '0;
            match_reg  <= 1'b1;
            slot_reg   <= '0;
            opened_reg <= 1'b0;
            offset_reg <= '0;
            pad_reg    <= 1'b0;
        end
        else if (fire)
        begin
            cpos_reg   <= cpos_next;
            plen_reg   <= plen_next;
            match_reg  <= match_next;
            slot_reg   <= slot_next;
            opened_reg <= opened_next;
            offset_reg <= offset_next;
            pad_reg    <= pad_next;
        end
    end

    // write and read never hit the same entry in one cycle
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            word_mem[cpos_reg] <= ch;
        end
        rd_data_reg <= word_mem[fire ? cpos_next : cpos_reg];
    end

endmodule
`default_nettype wire

// ===== hdl/front_coding_block_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// front_coding_block_encoder
// Front-codes a sorted word stream in blocks, with block index entries.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one transaction per command (character, end of word, flush).
//   result : data bytes (kind 0) and block index entries (kind 1); last marks
//            the final result of one item.
// An accepted item sits in an input register; while the output register
// is free, one coder step per cycle forms at most one result into it.
// Throughput is one item per cycle while each item gives at most one
// result and the receiver does not stall; an item with more results holds
// the input until its last one (up to WORDS_PER_BLOCK + 3 results on a flush
// that ends the last word of a block and then writes a whole empty block).
// The coder step and its word-store read set this rate.
// Reset clears the coding state and both valid flags; the previous-word
// store is not cleared, and is only read where the last word wrote it.
// When the receiver stalls, the result waits in the output register, one
// further item is held in the input register, then item ready drops.
// ----------------------------------------------------------------------------
module front_coding_block_encoder #(
    parameter int WORDS_PER_BLOCK = 16,
    parameter int WORD_BYTES      = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fcbe_chan_if.sink          item,
    fcbe_chan_if.source        result
);
    import fcbe_pkg::*;

    item_t   item_reg;
    logic    busy_reg;
    result_t out_reg;
    logic    out_valid_reg;

    step_t   step;
    logic    out_free;
    logic    fire;
    logic    take;

    assign out_free   = !out_valid_reg || result.ready;
    assign fire       = busy_reg && out_free;
    assign item.ready = !busy_reg || (fire && step.done);
    assign take       = item.valid && item.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    fcbe_coder #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .WORD_BYTES      (WORD_BYTES)
    ) u_coder (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (item_reg.cmd),
        .ch    (item_reg.ch),
        .fire  (fire),
        .step  (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
            end
            else if (fire && step.done)
            begin
                busy_reg <= 1'b0;
            end

            if (fire && step.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item.data;
        end
        if (fire && step.emit)
        begin
            out_reg.kind         <= step.kind;
            out_reg.data_byte    <= step.data_byte;
            out_reg.index_offset <= step.index_offset;
            out_reg.last         <= step.done;
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the front-coding block encoder. A directed word
// list and random sorted-like word streams are sent one command per
// transaction. Each command is front-coded in the bench as it is accepted,
// and every result transaction is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import fcbe_pkg::*;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int WORD_BYTES      = 32;
    localparam int RANDOM_ITEMS    = 430;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_CYCLES     = 80;
    localparam int HOLD_AFTER      = 300;
    localparam int CALM_FROM       = 150;
    localparam int CALM_TO         = 240;

    logic clk;
    logic rst_n;

    fcbe_chan_if #(.data_t(item_t))   item_ch ();
    fcbe_chan_if #(.data_t(result_t)) result_ch ();

    front_coding_block_encoder #(
        .WORDS_PER_BLOCK(WORDS_PER_BLOCK),
        .WORD_BYTES     (WORD_BYTES)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    // commands waiting to be sent, coded bytes waiting to come out
    item_t   word_stream [$];
    result_t due_codes [$];

    // encoder state mirror
    logic [7:0]  word_store [WORD_BYTES];
    int unsigned prev_len;
    int unsigned char_pos;
    logic        matching;
    int unsigned slot;
    logic        block_open;
    logic [31:0] data_offset;

    int          errors;
    int          n_taken;
    int          n_queued;
    int          cycle_count;
    int          hold_left;
    logic        hold_done;
    logic        item_fire;

    // ------------------------------------------------------------------
    // Front-coding prediction
    // ------------------------------------------------------------------
    function void note_result(logic k, logic [7:0] b, logic [31:0] off);
        result_t r;
        r.kind         = k;
        r.data_byte    = b;
        r.index_offset = off;
        r.last         = 1'b0;
        due_codes.push_back(r);
    endfunction

    function void note_data(logic [7:0] b);
        note_result(KIND_DATA, b, 32'd0);
        data_offset = data_offset + 32'd1;
    endfunction

    function void open_block();
        if (!block_open)
        begin
            note_result(KIND_INDEX, 8'h00, data_offset);
            block_open = 1'b1;
        end
    endfunction

    function void next_slot();
        prev_len = char_pos;
        char_pos = 0;
        matching = 1'b1;
        slot++;
        if (slot >= WORDS_PER_BLOCK)
        begin
            slot       = 0;
            block_open = 1'b0;
        end
    endfunction

    function void close_word();
        open_block();
        if (slot != 0 && char_pos > 0 && matching)
            note_data(8'(char_pos));
        note_data(8'h00);
        next_slot();
    endfunction

    function void add_char(logic [7:0] c);
        int unsigned pos;
        pos = char_pos;
        open_block();
        if (pos >= WORD_BYTES - 1)
            return;   // overlong word: extra characters are dropped
        if (slot == 0)
            note_data(c);
        else if (matching)
        begin
            if (!(pos < prev_len && word_store[pos] == c))
            begin
                note_data(8'(pos));
                note_data(c);
                matching = 1'b0;
            end
        end
        else
            note_data(c);
        word_store[pos] = c;
        char_pos = pos + 1;
    endfunction

    function void flush_block();
        if (char_pos > 0)
            close_word();
        // nothing started in this block: emit a whole empty one
        if (!block_open && slot == 0)
        begin
            open_block();
            note_data(8'h00);
            next_slot();
        end
        while (slot != 0)
            close_word();
    endfunction

    function void front_code_item(item_t it);
        int first;
        first = due_codes.size();
        case (cmd_e'(it.cmd))
            CMD_CHAR:  if (it.ch != 8'h00) add_char(it.ch);
            CMD_END:   close_word();
            CMD_FLUSH: flush_block();
            default:   ;
        endcase
        if (due_codes.size() > first)
            due_codes[due_codes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function void queue_cmd(cmd_e c, logic [7:0] b);
        item_t it;
        it.cmd = c;
        it.ch  = b;
        word_stream.push_back(it);
        if (!(c == CMD_NONE || (c == CMD_CHAR && b == 8'h00)))
            n_queued++;
    endfunction

    function logic [7:0] pick_char();
        if ($urandom_range(9) < 7)
            return 8'($urandom_range(8'h7a, 8'h61));
        return 8'($urandom_range(255, 1));
    endfunction

    function void build_random_stream();
        logic [7:0] last_word [$];
        logic [7:0] new_word [$];
        int         keep;
        int         extra;
        n_queued = 0;
        while (n_queued < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 8)
            begin
                // noise: any command, any byte
                queue_cmd(cmd_e'($urandom_range(3)), 8'($urandom_range(255)));
            end
            else
            begin
                keep  = $urandom_range(last_word.size());
                extra = ($urandom_range(19) == 0) ? $urandom_range(40, 28)
                                                  : $urandom_range(8);
                new_word.delete();
                for (int i = 0; i < keep; i++)
                    new_word.push_back(last_word[i]);
                for (int i = 0; i < extra; i++)
                    new_word.push_back(pick_char());
                foreach (new_word[i])
                    queue_cmd(CMD_CHAR, new_word[i]);
                // some words are cut short by a flush
                queue_cmd(cmd_e'(($urandom_range(9) == 0) ? CMD_FLUSH : CMD_END), 8'h00);
                last_word = new_word;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, driver, receiver, monitor
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function logic calm_window();
        return n_taken >= CALM_FROM && n_taken < CALM_TO;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            item_ch.valid <= 1'b0;
        else if (!item_ch.valid || item_fire)
        begin
            if (word_stream.size() > 0 &&
                (calm_window() || hold_left > 0 || $urandom_range(99) >= 25))
            begin
                item_ch.valid <= 1'b1;
                item_ch.data  <= word_stream.pop_front();
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (!hold_done && n_taken >= HOLD_AFTER)
        begin
            // long receiver stall so the encoder backs up into the input
            result_ch.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end
        else
            result_ch.ready <= calm_window() || $urandom_range(99) >= 25;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        item_fire <= rst_n && item_ch.valid && item_ch.ready;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (due_codes.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: kind %0d byte %02h offset %0d last %0d",
                             got.kind, got.data_byte, got.index_offset, got.last);
                errors++;
            end
            else
            begin
                want = due_codes.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.index_offset !== want.index_offset || got.last !== want.last)
                begin
                    if (errors < 10)
                        $display(
                            "mismatch exp/act: k %0d/%0d b %02h/%02h off %0d/%0d last %0d/%0d",
                            want.kind, got.kind, want.data_byte, got.data_byte,
                            want.index_offset, got.index_offset,
                            want.last, got.last);
                    errors++;
                end
            end
        end
        // predict after checking so the oldest expectation stays in front
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            front_code_item(item_ch.data);
            n_taken++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        item_fire       = 1'b0;
        errors          = 0;
        n_taken         = 0;
        cycle_count     = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        foreach (word_store[i])
            word_store[i] = 8'h00;
        prev_len    = 0;
        char_pos    = 0;
        matching    = 1'b1;
        slot        = 0;
        block_open  = 1'b0;
        data_offset = 32'd0;

        // empty block right after reset, then a second one
        queue_cmd(CMD_FLUSH, 8'h00);
        queue_cmd(CMD_FLUSH, 8'h00);
        // verbatim first word, then a longer and a repeated word
        queue_cmd(CMD_CHAR, "a");
        queue_cmd(CMD_CHAR, "b");
        queue_cmd(CMD_END, 8'h00);
        queue_cmd(CMD_CHAR, "a");
        queue_cmd(CMD_CHAR, "b");
        queue_cmd(CMD_CHAR, "c");
        queue_cmd(CMD_END, 8'h00);
        queue_cmd(CMD_CHAR, "a");
        queue_cmd(CMD_CHAR, "b");
        queue_cmd(CMD_END, 8'h00);
        // empty word, then ignored zero character and unused command
        queue_cmd(CMD_END, 8'h00);
        queue_cmd(CMD_CHAR, 8'h00);
        queue_cmd(CMD_NONE, 8'hff);
        // byte extremes, then a flush in the middle of the word
        queue_cmd(CMD_CHAR, 8'hff);
        queue_cmd(CMD_CHAR, 8'h01);
        queue_cmd(CMD_CHAR, 8'h80);
        queue_cmd(CMD_FLUSH, 8'h00);
        queue_cmd(CMD_CHAR, "z");
        queue_cmd(CMD_END, 8'h00);
        queue_cmd(CMD_FLUSH, 8'h00);

        build_random_stream();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (word_stream.size() != 0 || item_ch.valid || due_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
